@@ rtl/huffman_tree_build_and_decode_defines.svh @@
// ----------------------------------------------------------------------------
// huffman tree assertion macros
// Shared assertion macros for the huffman tree build and decode block.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_BUILD_AND_DECODE_DEFINES_SVH
`define HUFFMAN_TREE_BUILD_AND_DECODE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define HTB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication outside reset
`define HTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/htb_pkg.sv @@
// ----------------------------------------------------------------------------
// htb_pkg
// Types and codes shared by the huffman tree build and decode modules.
// ----------------------------------------------------------------------------
package htb_pkg;

    // item opcodes
    localparam logic [1:0] OP_ADD_LENGTH = 2'd0;
    localparam logic [1:0] OP_ADD_SYMBOL = 2'd1;
    localparam logic [1:0] OP_DECODE     = 2'd2;

    // result status codes
    localparam logic [2:0] ST_BUILD_OK   = 3'd0;
    localparam logic [2:0] ST_BUILD_FAIL = 3'd1;
    localparam logic [2:0] ST_MORE       = 3'd2;
    localparam logic [2:0] ST_SYMBOL     = 3'd3;
    localparam logic [2:0] ST_DEC_FAIL   = 3'd4;

    // child slot kinds (slot code: 0 empty, 1 leaf, link + 2)
    localparam int SLOT_EMPTY = 0;
    localparam int SLOT_LEAF  = 1;

    // sequencer states
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FIND   = 8'b0000_0010,
        S_CHECK  = 8'b0000_0100,
        S_APPEND = 8'b0000_1000,
        S_LEAF   = 8'b0001_0000,
        S_DEC    = 8'b0010_0000,
        S_INIT   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

endpackage

@@ rtl/htb_node_mem.sv @@
// ----------------------------------------------------------------------------
// htb_node_mem
// Node pool memory: one word per node holding parent, depth, both child
// slots and both leaf symbols. One write port, one registered read port.
// ----------------------------------------------------------------------------
module htb_node_mem #(
    parameter int AW = 10,
    parameter int DW = 64
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/huffman_tree_build_and_decode.sv @@
// ----------------------------------------------------------------------------
// huffman_tree_build_and_decode
// Builds canonical Huffman trees in a shared node pool and decodes them
// one bit per request.
//
//  channel  | signals                                   | direction
//  in       | in_valid/in_ready, opcode .. code_bit      | request in
//  out      | out_valid/out_ready, status, symbol        | result out
//  cfg      | cfg_valid/cfg_ready, cfg_data              | register write
//
// A decode request issues its node read at acceptance, evaluates the node in
// the next cycle and presents the result in the one after; no new request is
// taken until the result has left. A successful build walks parent nodes with
// a read and a check per node visited, appends each node with a parent link
// and a node write, and adds acceptance and output steps plus a leaf step for
// add symbol. The pool memory's single read port sets these steps. Reset
// clears the sequencer state and table and walk registers only; the pool is
// written before it is read. A stalled output holds the block.
// ----------------------------------------------------------------------------
module huffman_tree_build_and_decode #(
    parameter int MAX_NODES       = 1024,
    parameter int MAX_TABLES      = 4,
    parameter int MAX_CODE_LENGTH = 16,
    parameter int SYMBOL_BITS     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [1:0]  table_select,
    input  logic [15:0] symbol_value,
    input  logic        code_bit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] symbol,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);

`include "huffman_tree_build_and_decode_defines.svh"

    localparam int AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int PW  = AW + 1;                 // index with room for none / total
    localparam int LW  = $clog2(MAX_CODE_LENGTH + 2);
    localparam int CW  = AW + 2;                 // slot code width
    localparam int TW  = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int SB  = SYMBOL_BITS;
    localparam int DW  = PW + LW + 2 * CW + 2 * SB;
    localparam logic [PW-1:0] NONE = {PW{1'b1}};
    localparam logic [PW-1:0] POOL_MAX = PW'(MAX_NODES);

    // node word fields
    typedef struct packed {
        logic [PW-1:0] parent;
        logic [LW-1:0] depth;
        logic [CW-1:0] child1;
        logic [CW-1:0] child0;
        logic [SB-1:0] sym1;
        logic [SB-1:0] sym0;
    } node_t;

    // table registers
    logic [PW-1:0] root_reg [MAX_TABLES];
    logic [PW-1:0] newest_reg [MAX_TABLES];
    logic [PW-1:0] total_reg [MAX_TABLES];
    logic [LW-1:0] clen_reg [MAX_TABLES];
    logic [PW-1:0] pool_reg;
    logic          walk_reg;
    logic [AW-1:0] walk_node_reg;
    logic [2:0]    tcount_reg;

    // request and working registers
    htb_pkg::state_t state_reg;
    logic [1:0]      op_reg;
    logic [TW-1:0]   tsel_reg;
    logic [SB-1:0]   sym_reg;
    logic            bit_reg;
    logic [PW-1:0]   cur_reg;
    node_t           cur_node_reg;
    logic [2:0]      status_reg;
    logic [15:0]     osym_reg;

    // memory ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    node_t         mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;
    node_t         rnode;

    htb_node_mem #(.AW(AW), .DW(DW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );
    assign rnode = node_t'(mem_rdata);

    // handshakes
    assign in_ready  = (state_reg == htb_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == htb_pkg::S_OUT);
    assign status    = status_reg;
    assign symbol    = osym_reg;

    // request decode
    logic [2:0] lim;
    logic       sel_ok;
    logic [TW-1:0] in_tsel;
    assign lim     = ({29'd0, tcount_reg} < 32'(MAX_TABLES)) ? tcount_reg
                                                             : 3'(MAX_TABLES);
    assign sel_ok  = {1'b0, table_select} < lim;
    assign in_tsel = TW'(table_select);

    // decode helpers on current node word
    logic [CW-1:0] dslot;
    logic [SB-1:0] dsym;
    logic [CW-1:0] dlink;
    assign dslot = bit_reg ? rnode.child1 : rnode.child0;
    assign dsym  = bit_reg ? rnode.sym1 : rnode.sym0;
    assign dlink = dslot - CW'(2);

    // open slot test on node read back
    logic rd_open;
    assign rd_open = (rnode.child0 == CW'(htb_pkg::SLOT_EMPTY)) ||
                     (rnode.child1 == CW'(htb_pkg::SLOT_EMPTY));

    // memory write select
    logic          wr_parent;   // update slot of cur_node with new link
    logic          wr_leaf;
    node_t         upd_node;
    node_t         new_node;
    always_comb
    begin
        upd_node = cur_node_reg;
        if (wr_leaf)
        begin
            if (cur_node_reg.child0 == CW'(htb_pkg::SLOT_EMPTY))
            begin
                upd_node.child0 = CW'(htb_pkg::SLOT_LEAF);
                upd_node.sym0   = sym_reg;
            end
            else
            begin
                upd_node.child1 = CW'(htb_pkg::SLOT_LEAF);
                upd_node.sym1   = sym_reg;
            end
        end
        else if (cur_node_reg.child0 == CW'(htb_pkg::SLOT_EMPTY))
        begin
            upd_node.child0 = CW'(pool_reg) + CW'(2);
        end
        else
        begin
            upd_node.child1 = CW'(pool_reg) + CW'(2);
        end
        new_node.parent = cur_reg;
        new_node.depth  = (cur_reg == NONE) ? LW'(1) : cur_node_reg.depth + LW'(1);
        new_node.child0 = '0;
        new_node.child1 = '0;
        new_node.sym0   = '0;
        new_node.sym1   = '0;
    end

    // sequencer
    logic cur_open;
    assign cur_open = (cur_node_reg.child0 == CW'(htb_pkg::SLOT_EMPTY)) ||
                      (cur_node_reg.child1 == CW'(htb_pkg::SLOT_EMPTY));

    // append refused: pool full, bad parent or parent without a free slot
    logic append_fail;
    assign append_fail = (pool_reg >= POOL_MAX) ||
                         (cur_reg != NONE && (cur_reg >= pool_reg || !cur_open));

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(pool_reg);
        mem_wdata = new_node;
        mem_raddr = AW'(cur_reg);
        wr_parent = 1'b0;
        wr_leaf   = 1'b0;
        unique case (state_reg)
            htb_pkg::S_IDLE:
            begin
                // decode start node read at acceptance
                mem_raddr = walk_reg ? walk_node_reg : AW'(root_reg[in_tsel]);
            end
            htb_pkg::S_APPEND:
            begin
                // link slot in parent first, then write new node
                if (cur_reg != NONE && !append_fail)
                begin
                    wr_parent = 1'b1;
                end
            end
            htb_pkg::S_LEAF:
            begin
                wr_leaf = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (state_reg == htb_pkg::S_INIT)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(pool_reg);
            mem_wdata = new_node;
        end
        else if (state_reg == htb_pkg::S_APPEND && wr_parent)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(cur_reg);
            mem_wdata = upd_node;
        end
        else if (state_reg == htb_pkg::S_LEAF)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(cur_reg);
            mem_wdata = upd_node;
        end
    end

    integer i;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= htb_pkg::S_IDLE;
            pool_reg      <= '0;
            walk_reg      <= 1'b0;
            walk_node_reg <= '0;
            tcount_reg    <= 3'd4;
            for (i = 0; i < MAX_TABLES; i++)
            begin
                root_reg[i]   <= NONE;
                newest_reg[i] <= NONE;
                total_reg[i]  <= '0;
                clen_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tcount_reg <= cfg_data;
            end
            unique case (state_reg)
                htb_pkg::S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg   <= opcode;
                        tsel_reg <= in_tsel;
                        sym_reg  <= SB'(symbol_value);
                        bit_reg  <= code_bit;
                        osym_reg <= '0;
                        if (opcode == htb_pkg::OP_DECODE)
                        begin
                            if (walk_reg)
                            begin
                                cur_reg   <= {1'b0, walk_node_reg};
                                state_reg <= htb_pkg::S_DEC;
                            end
                            else if (sel_ok && root_reg[in_tsel] != NONE &&
                                     root_reg[in_tsel] < pool_reg)
                            begin
                                cur_reg   <= root_reg[in_tsel];
                                state_reg <= htb_pkg::S_DEC;
                            end
                            else
                            begin
                                status_reg <= htb_pkg::ST_DEC_FAIL;
                                walk_reg   <= 1'b0;
                                state_reg  <= htb_pkg::S_OUT;
                            end
                        end
                        else if ((opcode == htb_pkg::OP_ADD_LENGTH ||
                                  opcode == htb_pkg::OP_ADD_SYMBOL) && sel_ok)
                        begin
                            if (opcode == htb_pkg::OP_ADD_LENGTH &&
                                32'(clen_reg[in_tsel]) >= MAX_CODE_LENGTH)
                            begin
                                status_reg <= htb_pkg::ST_BUILD_FAIL;
                                state_reg  <= htb_pkg::S_OUT;
                            end
                            else if (opcode == htb_pkg::OP_ADD_SYMBOL &&
                                     clen_reg[in_tsel] == '0)
                            begin
                                status_reg <= htb_pkg::ST_BUILD_FAIL;
                                state_reg  <= htb_pkg::S_OUT;
                            end
                            else if (total_reg[in_tsel] == '0)
                            begin
                                // empty table: append root, parent none
                                cur_reg   <= NONE;
                                state_reg <= htb_pkg::S_APPEND;
                            end
                            else
                            begin
                                cur_reg   <= newest_reg[in_tsel];
                                state_reg <= htb_pkg::S_FIND;
                            end
                        end
                        else
                        begin
                            status_reg <= htb_pkg::ST_BUILD_FAIL;
                            state_reg  <= htb_pkg::S_OUT;
                        end
                    end
                end
                htb_pkg::S_FIND:
                begin
                    // walk step: address issued, check the node next
                    if (cur_reg < pool_reg)
                    begin
                        state_reg <= htb_pkg::S_CHECK;
                    end
                    else
                    begin
                        status_reg <= htb_pkg::ST_BUILD_FAIL;
                        state_reg  <= htb_pkg::S_OUT;
                    end
                end
                htb_pkg::S_CHECK:
                begin
                    cur_node_reg <= rnode;
                    if (rd_open)
                    begin
                        if (op_reg == htb_pkg::OP_ADD_LENGTH ||
                            32'(rnode.depth) >= 32'(clen_reg[tsel_reg]))
                        begin
                            state_reg <= (op_reg == htb_pkg::OP_ADD_LENGTH) ?
                                         htb_pkg::S_APPEND : htb_pkg::S_LEAF;
                        end
                        else
                        begin
                            state_reg <= htb_pkg::S_APPEND;
                        end
                    end
                    else
                    begin
                        cur_reg   <= rnode.parent;
                        state_reg <= htb_pkg::S_FIND;
                    end
                end
                htb_pkg::S_APPEND:
                begin
                    if (append_fail)
                    begin
                        status_reg <= htb_pkg::ST_BUILD_FAIL;
                        state_reg  <= htb_pkg::S_OUT;
                    end
                    else
                    begin
                        state_reg <= htb_pkg::S_INIT;
                    end
                end
                htb_pkg::S_INIT:
                begin
                    // new node written this cycle
                    cur_node_reg <= new_node;
                    cur_reg      <= pool_reg;
                    pool_reg     <= pool_reg + PW'(1);
                    newest_reg[tsel_reg] <= pool_reg;
                    total_reg[tsel_reg]  <= total_reg[tsel_reg] + PW'(1);
                    if (root_reg[tsel_reg] == NONE)
                    begin
                        root_reg[tsel_reg] <= pool_reg;
                    end
                    if (op_reg == htb_pkg::OP_ADD_LENGTH)
                    begin
                        clen_reg[tsel_reg] <= clen_reg[tsel_reg] + LW'(1);
                        status_reg <= htb_pkg::ST_BUILD_OK;
                        state_reg  <= htb_pkg::S_OUT;
                    end
                    else if (32'(new_node.depth) >= 32'(clen_reg[tsel_reg]))
                    begin
                        state_reg <= htb_pkg::S_LEAF;
                    end
                    else
                    begin
                        state_reg <= htb_pkg::S_APPEND;
                    end
                end
                htb_pkg::S_LEAF:
                begin
                    status_reg <= cur_open ? htb_pkg::ST_BUILD_OK
                                           : htb_pkg::ST_BUILD_FAIL;
                    state_reg  <= htb_pkg::S_OUT;
                end
                htb_pkg::S_DEC:
                begin
                    // node read issued at acceptance; pick the slot for the bit
                    state_reg <= htb_pkg::S_OUT;
                    if (dslot == CW'(htb_pkg::SLOT_EMPTY))
                    begin
                        status_reg <= htb_pkg::ST_DEC_FAIL;
                        walk_reg   <= 1'b0;
                    end
                    else if (dslot == CW'(htb_pkg::SLOT_LEAF))
                    begin
                        status_reg <= htb_pkg::ST_SYMBOL;
                        osym_reg   <= 16'(dsym);
                        walk_reg   <= 1'b0;
                    end
                    else if (dlink < {1'b0, pool_reg})
                    begin
                        status_reg    <= htb_pkg::ST_MORE;
                        walk_node_reg <= AW'(dlink);
                        walk_reg      <= 1'b1;
                    end
                    else
                    begin
                        status_reg <= htb_pkg::ST_DEC_FAIL;
                        walk_reg   <= 1'b0;
                    end
                end
                htb_pkg::S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= htb_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= htb_pkg::S_IDLE;
                end
            endcase
        end
    end

    // assertions
    `HTB_ASSERT_IMPL(a_pool_bound, clk, rst_n, 1'b1, pool_reg <= POOL_MAX,
        "pool count beyond capacity")
    `HTB_ASSERT_IMPL(a_ready_out, clk, rst_n, out_valid, !in_ready,
        "input taken while result pending")
    `HTB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status), "result changed while stalled")
    `HTB_ASSERT_IMPL(a_sym_zero, clk, rst_n, out_valid && status != htb_pkg::ST_SYMBOL,
        symbol == 16'd0, "symbol nonzero without decode")

endmodule

@@ tb/sv/htb_checker.sv @@
// ----------------------------------------------------------------------------
// htb_checker
// Watches the request, result and register channels of the huffman tree
// block, predicts each result from its own model of the node pool and
// compares results in order against the predictions.
// ----------------------------------------------------------------------------
module htb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [1:0]  table_select,
    input  logic [15:0] symbol_value,
    input  logic        code_bit,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [15:0] symbol,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output int          decoded_total
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NPOOL  = 1024;
    localparam int unsigned NTAB   = 4;
    localparam int unsigned MAXLEN = 16;
    localparam int unsigned NIL    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] symbol;
    } huff_result_t;

    // shadow copy of the node pool and table registers
    int unsigned pool_parent [NPOOL];
    int unsigned pool_depth  [NPOOL];
    int unsigned pool_slot   [2*NPOOL];
    int unsigned pool_sym    [2*NPOOL];
    int unsigned tab_root    [NTAB];
    int unsigned tab_newest  [NTAB];
    int unsigned tab_nodes   [NTAB];
    int unsigned tab_len     [NTAB];
    int unsigned nodes_used;
    bit          walking;
    int unsigned walk_at;
    logic [2:0]  tables_enabled;

    huff_result_t expected_results[$];

    // first node with a free slot on the path up from the newest node
    function automatic int unsigned open_node(int unsigned t);
        int unsigned n;
        n = tab_newest[t];
        if (tab_nodes[t] == 0)
            return n;
        while (n < nodes_used) begin
            if (pool_slot[2*n] == htb_pkg::SLOT_EMPTY ||
                pool_slot[2*n+1] == htb_pkg::SLOT_EMPTY)
                return n;
            n = pool_parent[n];
        end
        return NIL;
    endfunction

    function automatic int unsigned grow_node(int unsigned t, int unsigned par);
        int unsigned tgt;
        tgt = nodes_used;
        if (tgt >= NPOOL)
            return NIL;
        if (par != NIL) begin
            if (par >= tgt)
                return NIL;
            if (pool_slot[2*par] == htb_pkg::SLOT_EMPTY)
                pool_slot[2*par] = tgt + 2;
            else if (pool_slot[2*par+1] == htb_pkg::SLOT_EMPTY)
                pool_slot[2*par+1] = tgt + 2;
            else
                return NIL;
        end
        pool_parent[tgt] = par;
        pool_depth[tgt]  = (par != NIL) ? pool_depth[par] + 1 : 1;
        pool_slot[2*tgt] = htb_pkg::SLOT_EMPTY;
        pool_slot[2*tgt+1] = htb_pkg::SLOT_EMPTY;
        pool_sym[2*tgt] = 0;
        pool_sym[2*tgt+1] = 0;
        if (tab_root[t] == NIL)
            tab_root[t] = tgt;
        tab_newest[t] = tgt;
        tab_nodes[t]++;
        nodes_used++;
        return tgt;
    endfunction

    function automatic bit grow_length(int unsigned t);
        int unsigned n;
        if (tab_len[t] >= MAXLEN)
            return 0;
        n = open_node(t);
        if (n == NIL && tab_nodes[t] != 0)
            return 0;
        if (grow_node(t, n) == NIL)
            return 0;
        tab_len[t]++;
        return 1;
    endfunction

    function automatic bit place_symbol(int unsigned t, logic [15:0] s);
        int unsigned n;
        if (tab_len[t] == 0)
            return 0;
        n = open_node(t);
        if (n == NIL)
            return 0;
        while (pool_depth[n] < tab_len[t]) begin
            n = grow_node(t, n);
            if (n == NIL)
                return 0;
        end
        if (pool_slot[2*n] == htb_pkg::SLOT_EMPTY) begin
            pool_slot[2*n] = htb_pkg::SLOT_LEAF;
            pool_sym[2*n] = s;
        end else if (pool_slot[2*n+1] == htb_pkg::SLOT_EMPTY) begin
            pool_slot[2*n+1] = htb_pkg::SLOT_LEAF;
            pool_sym[2*n+1] = s;
        end else begin
            return 0;
        end
        return 1;
    endfunction

    // result of one request, updating the shadow state
    function automatic huff_result_t predict_result(logic [1:0] op, logic [1:0] sel,
                                                    logic [15:0] s, logic b);
        huff_result_t r;
        int unsigned  lim;
        bit           ok;
        int unsigned  n;
        int unsigned  c;
        lim = (tables_enabled < NTAB) ? tables_enabled : NTAB;
        r.status = htb_pkg::ST_BUILD_FAIL;
        r.symbol = '0;
        if (op == htb_pkg::OP_ADD_LENGTH || op == htb_pkg::OP_ADD_SYMBOL) begin
            ok = 0;
            if (sel < lim)
                ok = (op == htb_pkg::OP_ADD_LENGTH) ? grow_length(sel)
                                                    : place_symbol(sel, s);
            r.status = ok ? htb_pkg::ST_BUILD_OK : htb_pkg::ST_BUILD_FAIL;
        end else if (op == htb_pkg::OP_DECODE) begin
            n = NIL;
            if (walking)
                n = walk_at;
            else if (sel < lim && tab_root[sel] != NIL && tab_root[sel] < nodes_used)
                n = tab_root[sel];
            if (n == NIL || n >= NPOOL) begin
                r.status = htb_pkg::ST_DEC_FAIL;
                walking = 0;
            end else begin
                c = pool_slot[2*n + b];
                if (c == htb_pkg::SLOT_EMPTY) begin
                    r.status = htb_pkg::ST_DEC_FAIL;
                    walking = 0;
                end else if (c == htb_pkg::SLOT_LEAF) begin
                    r.status = htb_pkg::ST_SYMBOL;
                    r.symbol = pool_sym[2*n + b];
                    walking = 0;
                end else if (c - 2 < nodes_used) begin
                    r.status = htb_pkg::ST_MORE;
                    walk_at = c - 2;
                    walking = 1;
                end else begin
                    r.status = htb_pkg::ST_DEC_FAIL;
                    walking = 0;
                end
            end
        end
        return r;
    endfunction

    // watch channels, predict on requests, compare on results
    always @(posedge clk or negedge rst_n)
    begin
        huff_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < NTAB; i++) begin
                tab_root[i] = NIL;
                tab_newest[i] = NIL;
                tab_nodes[i] = 0;
                tab_len[i] = 0;
            end
            nodes_used = 0;
            walking = 0;
            walk_at = 0;
            tables_enabled = 3'd4;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
            decoded_total = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                tables_enabled = cfg_data;
            if (in_valid && in_ready)
                expected_results.push_back(
                    predict_result(opcode, table_select, symbol_value, code_bit));
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result status=%0d symbol=%h", status, symbol);
                end else begin
                    want = expected_results.pop_front();
                    if (want.status == htb_pkg::ST_SYMBOL)
                        decoded_total++;
                    if (status !== want.status || symbol !== want.symbol) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected status=%0d symbol=%h,",
                                      " got status=%0d symbol=%h"},
                                     want.status, want.symbol, status, symbol);
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives build and decode requests into the huffman tree block across
// several table counts and idling patterns; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE = 120;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [1:0]  table_select;
    logic [15:0] symbol_value;
    logic        code_bit;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [15:0] symbol;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;

    int fail_count;
    int pending;
    int decoded_total;
    int cycles = 0;
    int send_idle_pct;
    int recv_stall_pct;
    int requests_sent;

    huffman_tree_build_and_decode uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .table_select(table_select),
        .symbol_value(symbol_value), .code_bit(code_bit),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .symbol(symbol),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    htb_checker scoreboard (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .table_select(table_select),
        .symbol_value(symbol_value), .code_bit(code_bit),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .symbol(symbol),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .decoded_total(decoded_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // one request; called just after a rising edge, returns just after acceptance
    task automatic send_request(logic [1:0] op, logic [1:0] sel, logic [15:0] s, logic b);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        table_select <= sel;
        symbol_value <= s;
        code_bit     <= b;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        requests_sent++;
    endtask

    // wait for every result, then let any trailing work finish
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_table_count(logic [2:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count, int lim);
        int          r;
        logic [1:0]  op;
        logic [1:0]  sel;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 22)      op = htb_pkg::OP_ADD_LENGTH;
            else if (r < 50) op = htb_pkg::OP_ADD_SYMBOL;
            else if (r < 95) op = htb_pkg::OP_DECODE;
            else             op = OP_UNUSED;
            sel = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, lim - 1))
                                              : 2'($urandom_range(0, 3));
            send_request(op, sel, 16'($urandom), 1'($urandom));
            // one pause until the block has answered everything
            if (i == count / 2 && lim == 4) begin
                in_valid <= 1'b0;
                while (pending != 0) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = htb_pkg::OP_ADD_LENGTH;
        table_select = '0;
        symbol_value = '0;
        code_bit = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 3'd4;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        requests_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tables, unused opcode, short trees, length limit
        send_request(htb_pkg::OP_DECODE, 2'd0, 16'h0000, 1'b0);
        send_request(htb_pkg::OP_ADD_SYMBOL, 2'd0, 16'hAAAA, 1'b0);
        send_request(OP_UNUSED, 2'd0, 16'h0000, 1'b1);
        send_request(htb_pkg::OP_ADD_LENGTH, 2'd0, 16'h0000, 1'b0);
        send_request(htb_pkg::OP_ADD_SYMBOL, 2'd0, 16'hFFFF, 1'b0);
        send_request(htb_pkg::OP_ADD_SYMBOL, 2'd0, 16'h0000, 1'b1);
        send_request(htb_pkg::OP_ADD_SYMBOL, 2'd0, 16'h5555, 1'b0);
        send_request(htb_pkg::OP_DECODE, 2'd0, 16'h0000, 1'b0);
        send_request(htb_pkg::OP_DECODE, 2'd0, 16'hFFFF, 1'b1);
        send_request(htb_pkg::OP_ADD_LENGTH, 2'd1, 16'h0000, 1'b0);
        send_request(htb_pkg::OP_ADD_LENGTH, 2'd1, 16'h0000, 1'b0);
        send_request(htb_pkg::OP_ADD_SYMBOL, 2'd1, 16'h1234, 1'b0);
        send_request(htb_pkg::OP_DECODE, 2'd1, 16'h0000, 1'b0);
        // walk in progress ignores table select
        send_request(htb_pkg::OP_DECODE, 2'd3, 16'h0000, 1'b0);
        send_request(htb_pkg::OP_DECODE, 2'd1, 16'h0000, 1'b0);
        send_request(htb_pkg::OP_DECODE, 2'd1, 16'h0000, 1'b1);
        // length past the maximum on the last table
        for (int i = 0; i < 17; i++)
            send_request(htb_pkg::OP_ADD_LENGTH, 2'd3, 16'h0000, 1'b0);
        send_request(htb_pkg::OP_ADD_SYMBOL, 2'd3, 16'hFFFF, 1'b1);
        drain_results();

        // one table only: others are invalid
        write_table_count(3'd1);
        send_request(htb_pkg::OP_ADD_LENGTH, 2'd2, 16'h0000, 1'b0);
        send_request(htb_pkg::OP_DECODE, 2'd1, 16'h0000, 1'b0);
        send_request(htb_pkg::OP_DECODE, 2'd0, 16'h0000, 1'b0);
        send_request(htb_pkg::OP_ADD_SYMBOL, 2'd0, 16'h8001, 1'b0);
        random_phase(100, 1);
        drain_results();

        // random phases over table counts and idling patterns
        write_table_count(3'd2);
        send_idle_pct = 62;
        random_phase(100, 2);
        drain_results();

        write_table_count(3'd3);
        send_idle_pct = 0;
        recv_stall_pct = 62;
        random_phase(100, 3);
        drain_results();

        write_table_count(3'd4);
        send_idle_pct = 18;
        recv_stall_pct = 18;
        random_phase(100, 4);
        drain_results();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(100, 4);
        drain_results();

        $display("covered %0d requests over table counts 1 to 4 with varied idling",
                 requests_sent);
        $display("%0d symbols decoded, %0d failures", decoded_total, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
